### src/lcsl_pkg.sv
// Package for the longest common substring length unit.
// Holds widths, the per-beat cell control struct and the sequencer state type.
// No dependencies.
`default_nettype none

package lcsl_pkg;

  localparam int SYM_W   = 8;
  localparam int COUNT_W = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic             load;
    logic             query;
    logic             restart;
    logic             clear;
    logic [SYM_W-1:0] symbol;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_DRAIN = 2'b10
  } lcsl_state_t;

endpackage

`default_nettype wire

### src/lcsl_cell.sv
// One reference position of the unit: stored symbol, fill flag, run counter,
// local maximum and one stage of the maximum chain.
// Depends on lcsl_pkg.
`default_nettype none

module lcsl_cell
  import lcsl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cell_ctl_t          ctl,
  input  wire logic               prev_filled,
  input  wire logic [COUNT_W-1:0] prev_count,
  input  wire logic [COUNT_W-1:0] prev_max,
  output logic                    filled,
  output logic [COUNT_W-1:0]      count,
  output logic [COUNT_W-1:0]      max_out
);

  logic               held;
  logic [SYM_W-1:0]   sym;
  logic [COUNT_W-1:0] run;
  logic [COUNT_W-1:0] best;
  logic [COUNT_W-1:0] max_reg;
  logic               held_eff;
  logic               write;
  logic [COUNT_W-1:0] run_next;

  assign held_eff = held & ~ctl.restart;
  assign write    = ctl.load & ~held_eff & prev_filled;

  always_comb begin
    if (sym == ctl.symbol) begin
      run_next = (prev_count == COUNT_MAX) ? COUNT_MAX : prev_count + 1'b1;
    end else begin
      run_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= 1'b0;
      run     <= '0;
      best    <= '0;
      max_reg <= '0;
    end else begin
      held    <= held_eff | write;
      max_reg <= (prev_max > best) ? prev_max : best;
      if (ctl.restart || ctl.clear) begin
        run  <= '0;
        best <= '0;
      end else if (ctl.query && held) begin
        run <= run_next;
        if (run_next > best) begin
          best <= run_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (write) begin
      sym <= ctl.symbol;
    end
  end

  assign filled  = held_eff;
  assign count   = run;
  assign max_out = max_reg;

endmodule

`default_nettype wire

### src/longest_common_substring_length_unit.sv
// Longest common substring length unit.
// Input beats carry action, symbol and last; output beats carry common_length.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// A load beat (action 0) stores a reference symbol in the next free cell;
// the beat marked last closes the reference, and the next load starts a new
// one. Symbols beyond MAX_LEN cells are dropped.
// A query beat (action 1) updates every cell's run counter at once; outside
// a drain, loads and query beats without last are taken one per cycle.
// A query beat with last starts a drain of the maximum chain through all
// MAX_LEN cells, and in_stall is high until the result is ready. The row
// and the maximum then clear.
// One result waits in the output register; while out_stall holds it, input
// beats are still taken, but a further drain does not finish until the
// waiting result is taken.
// Reset (rst, synchronous) empties the reference and clears the row.
// Depends on lcsl_pkg and lcsl_cell.
`default_nettype none

module longest_common_substring_length_unit
  import lcsl_pkg::*;
#(
  parameter int MAX_LEN = 128
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               action,
  input  wire logic [SYM_W-1:0]   symbol,
  input  wire logic               last,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [COUNT_W-1:0]      common_length
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] DRAIN_END = CNT_W'(MAX_LEN);

  lcsl_state_t        state;
  logic [CNT_W-1:0]   drain_cnt;
  logic               reference_done;
  logic               in_accept;
  logic               drain_done;
  cell_ctl_t          ctl;

  logic               filled_chain [0:MAX_LEN];
  logic [COUNT_W-1:0] count_chain  [0:MAX_LEN];
  logic [COUNT_W-1:0] max_chain    [0:MAX_LEN];

  assign in_stall   = (state == ST_DRAIN);
  assign in_accept  = in_valid & ~in_stall;
  assign drain_done = (state == ST_DRAIN) && (drain_cnt == DRAIN_END)
                      && (!out_valid || !out_stall);

  always_comb begin
    ctl.load    = in_accept && (action == ACT_LOAD);
    ctl.query   = in_accept && (action == ACT_QUERY);
    ctl.restart = in_accept && (action == ACT_LOAD) && reference_done;
    ctl.clear   = drain_done;
    ctl.symbol  = symbol;
  end

  assign filled_chain[0] = 1'b1;
  assign count_chain[0]  = '0;
  assign max_chain[0]    = '0;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    lcsl_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .prev_filled (filled_chain[i]),
      .prev_count  (count_chain[i]),
      .prev_max    (max_chain[i]),
      .filled      (filled_chain[i+1]),
      .count       (count_chain[i+1]),
      .max_out     (max_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_RUN;
      drain_cnt      <= '0;
      reference_done <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (ctl.load) begin
        reference_done <= last;
      end
      if (drain_done) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_RUN: begin
          if (ctl.query && last) begin
            state     <= ST_DRAIN;
            drain_cnt <= '0;
          end
        end
        ST_DRAIN: begin
          if (drain_cnt != DRAIN_END) begin
            drain_cnt <= drain_cnt + 1'b1;
          end else if (drain_done) begin
            state <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (drain_done) begin
      common_length <= max_chain[MAX_LEN];
    end
  end

  a_last_query_drains: assert property (@(posedge clk) disable iff (rst)
    (in_accept && action == ACT_QUERY && last) |=> (state == ST_DRAIN))
    else $error("last query beat did not start a drain");

  a_result_after_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DRAIN && drain_cnt == DRAIN_END))
    else $error("result shown without a full drain");

  a_drain_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && drain_cnt != DRAIN_END) |=> (state == ST_DRAIN))
    else $error("drain left early");

  a_ref_closed: assert property (@(posedge clk) disable iff (rst)
    (in_accept && action == ACT_LOAD && last) |=> reference_done)
    else $error("reference not closed by last load beat");

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench for longest_common_substring_length_unit: directed and random
// reference/query sessions checked against an in-bench run-counter row.
// Depends on lcsl_pkg and the unit itself.
`timescale 1ns / 100ps

module tb;
  import lcsl_pkg::*;

  localparam int MAX_LEN = 128;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               action = ACT_LOAD;
  logic [SYM_W-1:0]   symbol = '0;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COUNT_W-1:0] common_length;

  longest_common_substring_length_unit #(.MAX_LEN(MAX_LEN)) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .symbol(symbol),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .common_length(common_length)
  );

  logic [SYM_W-1:0]   ref_syms [MAX_LEN];
  int                 ref_cnt = 0;
  bit                 ref_closed = 1'b0;
  int                 run_len [MAX_LEN];
  int                 best_run = 0;
  logic [COUNT_W-1:0] expected_lengths [$];
  logic [COUNT_W-1:0] want_len;

  int  err_cnt = 0;
  int  beats_sent = 0;
  int  lengths_predicted = 0;
  int  lengths_checked = 0;
  bit  no_idle = 1'b0;
  logic [SYM_W-1:0] sym_base = '0;
  logic [SYM_W-1:0] sym_mask = '1;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: errors");
    $finish;
  end

  function automatic void clear_runs();
    foreach (run_len[i]) run_len[i] = 0;
    best_run = 0;
  endfunction

  task automatic track_beat(input logic act, input logic [SYM_W-1:0] sym, input logic lst);
    int v;
    if (act == ACT_LOAD) begin
      if (ref_closed) begin
        ref_cnt = 0;
        ref_closed = 1'b0;
        clear_runs();
      end
      if (ref_cnt < MAX_LEN) begin
        ref_syms[ref_cnt] = sym;
        ref_cnt++;
      end
      if (lst) ref_closed = 1'b1;
    end else begin
      for (int p = ref_cnt - 1; p >= 0; p--) begin
        if (ref_syms[p] == sym) begin
          v = (p > 0) ? run_len[p-1] + 1 : 1;
          if (v > COUNT_MAX) v = COUNT_MAX;
          run_len[p] = v;
          if (v > best_run) best_run = v;
        end else begin
          run_len[p] = 0;
        end
      end
      if (lst) begin
        expected_lengths.push_back(best_run[COUNT_W-1:0]);
        lengths_predicted++;
        clear_runs();
      end
    end
  endtask

  task automatic send_beat(input logic act, input logic [SYM_W-1:0] sym, input logic lst);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 99) < 14) gap = $urandom_range(1, 2);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    symbol   <= sym;
    last     <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_beat(act, sym, lst);
    beats_sent++;
  endtask

  // Hold the input side until every pending length has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_lengths.size() != 0) @(posedge clk);
  endtask

  function automatic logic [SYM_W-1:0] pick_symbol();
    return sym_base ^ (SYM_W'($urandom) & sym_mask);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 14);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_lengths.size() == 0) begin
        $error("common_length: unexpected beat, actual %0d", common_length);
        err_cnt++;
      end else begin
        want_len = expected_lengths.pop_front();
        if (common_length !== want_len) begin
          $error("common_length expected %0d actual %0d", want_len, common_length);
          err_cnt++;
        end
        lengths_checked++;
      end
    end
  end

  task automatic test_empty_reference();
    send_beat(ACT_QUERY, 8'h00, 1'b1);
  endtask

  task automatic test_open_reference();
    send_beat(ACT_LOAD, 8'h00, 1'b0);
    send_beat(ACT_LOAD, 8'hFF, 1'b0);
    send_beat(ACT_QUERY, 8'hFF, 1'b1);
  endtask

  task automatic test_basic_match();
    send_beat(ACT_LOAD, 8'h41, 1'b1);
    send_beat(ACT_QUERY, 8'h00, 1'b0);
    send_beat(ACT_QUERY, 8'hFF, 1'b0);
    send_beat(ACT_QUERY, 8'h41, 1'b1);
    send_beat(ACT_QUERY, 8'h7F, 1'b0);
    send_beat(ACT_QUERY, 8'h80, 1'b0);
    send_beat(ACT_QUERY, 8'h41, 1'b1);
  endtask

  task automatic test_new_reference();
    send_beat(ACT_LOAD, 8'h80, 1'b1);
    send_beat(ACT_QUERY, 8'h80, 1'b1);
    send_beat(ACT_QUERY, 8'h80, 1'b0);
    send_beat(ACT_QUERY, 8'h80, 1'b1);
    send_beat(ACT_QUERY, 8'h01, 1'b1);
  endtask

  task automatic test_alternating_bits();
    send_beat(ACT_LOAD, 8'h55, 1'b0);
    send_beat(ACT_LOAD, 8'hAA, 1'b0);
    send_beat(ACT_LOAD, 8'h55, 1'b1);
    send_beat(ACT_QUERY, 8'hAA, 1'b0);
    send_beat(ACT_QUERY, 8'h55, 1'b0);
    send_beat(ACT_QUERY, 8'hAA, 1'b0);
    send_beat(ACT_QUERY, 8'h55, 1'b1);
  endtask

  task automatic run_session(input int ref_len, input bit wide);
    logic [SYM_W-1:0] ref_local [$];
    logic [SYM_W-1:0] s;
    int split;
    int nq;
    int qlen;
    int pos;
    sym_base = SYM_W'($urandom);
    case ($urandom_range(0, 3))
      0: sym_mask = 8'h01;
      1: sym_mask = 8'h03;
      2: sym_mask = 8'h0F;
      default: sym_mask = 8'hFF;
    endcase
    if (wide) sym_mask = 8'hFF;
    split = ($urandom_range(0, 99) < 10) ? $urandom_range(1, ref_len) : ref_len + 1;
    for (int k = 0; k < ref_len; k++) begin
      s = pick_symbol();
      ref_local.push_back(s);
      send_beat(ACT_LOAD, s, k == ref_len - 1);
      if (k == split - 1 && k != ref_len - 1) begin
        send_beat(ACT_QUERY, ref_local[$urandom_range(0, k)], 1'b0);
        send_beat(ACT_QUERY, pick_symbol(), 1'b1);
      end
    end
    nq = $urandom_range(1, 4);
    for (int q = 0; q < nq; q++) begin
      qlen = $urandom_range(1, 16);
      pos = $urandom_range(0, ref_len - 1);
      for (int k = 0; k < qlen; k++) begin
        if ($urandom_range(0, 99) < 65 && pos < ref_len) begin
          s = ref_local[pos];
          pos++;
        end else begin
          s = pick_symbol();
          pos = $urandom_range(0, ref_len - 1);
        end
        send_beat(ACT_QUERY, s, k == qlen - 1);
      end
    end
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 4))
        send_beat(logic'($urandom), SYM_W'($urandom), logic'($urandom));
    end
  endtask

  task automatic random_session();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) run_session($urandom_range(1, 12), 1'b0);
    else if (r < 97) run_session($urandom_range(13, MAX_LEN), 1'b0);
    else run_session($urandom_range(MAX_LEN + 1, MAX_LEN + 10), 1'b0);
  endtask

  task automatic test_capacity();
    logic [SYM_W-1:0] ref_local [$];
    logic [SYM_W-1:0] s;
    for (int k = 0; k < MAX_LEN + 2; k++) begin
      s = SYM_W'($urandom);
      ref_local.push_back(s);
      send_beat(ACT_LOAD, s, k == MAX_LEN + 1);
    end
    for (int k = 0; k < MAX_LEN; k++) send_beat(ACT_QUERY, ref_local[k], k == MAX_LEN - 1);
    for (int k = 2; k < MAX_LEN + 2; k++) send_beat(ACT_QUERY, ref_local[k], k == MAX_LEN + 1);
  endtask

  task automatic test_drain_pause();
    run_session($urandom_range(2, 8), 1'b0);
    settle();
    run_session($urandom_range(2, 8), 1'b1);
  endtask

  task automatic test_quiet_stretch();
    no_idle = 1'b1;
    repeat (5) random_session();
    no_idle = 1'b0;
  endtask

  task automatic test_random_sessions();
    while (beats_sent < 1650 || lengths_predicted < 48) begin
      random_session();
      if ($urandom_range(0, 99) < 5) settle();
    end
  endtask

  initial begin
    clear_runs();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_reference();
    test_open_reference();
    test_basic_match();
    test_new_reference();
    test_alternating_bits();
    test_capacity();
    test_drain_pause();
    test_quiet_stretch();
    test_random_sessions();
    settle();
    repeat (2 * MAX_LEN) @(posedge clk);
    $display("tb: %0d beats sent, %0d lengths checked", beats_sent, lengths_checked);
    $display("tb: covered empty, open, replaced and overflowing references, full-length runs");
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

### longest_common_substring_length_unit.f
src/lcsl_pkg.sv
src/lcsl_cell.sv
src/longest_common_substring_length_unit.sv
tb/tb.sv
